/* hdl/wiph_pkg.sv */
// wiph_pkg: constants and the result record type for the wlan ipv4 header parser
// no dependencies; imported by wlan_ipv4_header_parser
`timescale 1ns / 1ps

package wiph_pkg;

  // frame layout, offsets counted from the end of the preamble
  localparam logic [15:0] PREAMBLE_BYTES = 16'd24;
  localparam logic [15:0] FC_DS_OFFSET   = 16'd1;
  localparam logic [15:0] ADDR1_START    = 16'd4;
  localparam logic [15:0] ADDR2_START    = 16'd10;
  localparam logic [15:0] ADDR3_START    = 16'd16;
  localparam logic [15:0] ADDR4_START    = 16'd24;
  localparam logic [15:0] MAC_BYTES      = 16'd6;
  localparam logic [15:0] TYPE_START     = 16'd30;
  localparam logic [15:0] TYPE_BYTES     = 16'd2;
  localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  localparam logic [15:0] IP_ETHER_TYPE  = 16'h0800;

  // ip header byte indexes
  localparam logic [4:0] IPH_IHL      = 5'd0;
  localparam logic [4:0] IPH_LEN_HI   = 5'd2;
  localparam logic [4:0] IPH_LEN_LO   = 5'd3;
  localparam logic [4:0] IPH_CSUM_HI  = 5'd10;
  localparam logic [4:0] IPH_CSUM_LO  = 5'd11;
  localparam logic [4:0] IPH_SRC_LO   = 5'd12;
  localparam logic [4:0] IPH_SRC_HI   = 5'd15;
  localparam logic [4:0] IPH_DST_LO   = 5'd16;
  localparam logic [4:0] IPH_DST_HI   = 5'd19;

  localparam logic [1:0] DS_NONE   = 2'd0;
  localparam logic [1:0] DS_FROM   = 2'd1;
  localparam logic [1:0] DS_TO     = 2'd2;
  localparam logic [1:0] DS_BOTH   = 2'd3;

  typedef struct packed {
    logic        for_this_host;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [15:0] header_checksum;
    logic [15:0] packet_length;
    logic [5:0]  header_bytes;
    logic        is_ip_type;
    logic        four_address;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic        status;
  } result_t;

endpackage

/* hdl/wlan_ipv4_header_parser.sv */
// wlan_ipv4_header_parser: byte-serial 802.11 data frame parser with ipv4 header capture
// depends on wiph_pkg
`timescale 1ns / 1ps

// Takes one frame byte per clock when not stalled. After a 24-byte preamble it captures
// the DS bits of frame control, the three or four addresses, the LLC type and the
// 20-byte IPv4 header. On the accepted byte marked last it pushes one result into the
// output buffer: MACs chosen by the DS bits, IP fields, and whether the destination IP
// equals own_ip; a frame that ends before the IPv4 header is complete gives status 1
// and zero fields. Each accepted byte updates the frame state, so the sustained rate
// is one byte per clock when not stalled. Results go through a two-entry output
// buffer; the input stalls, for every byte alike, only while both entries are full.
// own_ip is written through cfg_we_i / cfg_wdata_i.
module wlan_ipv4_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        for_this_host_o,
  output logic [31:0] dest_ip_o,
  output logic [31:0] source_ip_o,
  output logic [15:0] header_checksum_o,
  output logic [15:0] packet_length_o,
  output logic [5:0]  header_bytes_o,
  output logic        is_ip_type_o,
  output logic        four_address_o,
  output logic [47:0] dest_mac_o,
  output logic [47:0] source_mac_o,
  output logic        status_o
);
  import wiph_pkg::*;

  logic [31:0] own_ip_q;
  logic [15:0] pos_q, pos_d;
  logic [1:0]  ds_q, ds_d;
  logic [47:0] addr1_q, addr1_d, addr2_q, addr2_d, addr3_q, addr3_d, addr4_q, addr4_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] iplen_q, iplen_d;
  logic [15:0] csum_q, csum_d;
  logic [31:0] ipsrc_q, ipsrc_d;
  logic [31:0] ipdst_q, ipdst_d;

  logic        main_v_q, skid_v_q;
  result_t     main_q, skid_q;
  result_t     res;

  logic        in_acc, push, pop;
  logic        in_body;
  logic [15:0] rel, ip_start, ip_off;
  logic [4:0]  hidx;
  logic        in_ip, complete;
  logic [47:0] da, sa;

  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !skid_v_q;
  assign push       = in_acc && last_byte_i;
  assign pop        = main_v_q && !out_stall_i;

  always_comb begin
    pos_d   = pos_q;
    ds_d    = ds_q;
    addr1_d = addr1_q;
    addr2_d = addr2_q;
    addr3_d = addr3_q;
    addr4_d = addr4_q;
    etype_d = etype_q;
    ihl_d   = ihl_q;
    iplen_d = iplen_q;
    csum_d  = csum_q;
    ipsrc_d = ipsrc_q;
    ipdst_d = ipdst_q;

    in_body = pos_q >= PREAMBLE_BYTES;
    rel     = pos_q - PREAMBLE_BYTES;

    if (in_body) begin
      if (rel == FC_DS_OFFSET) begin
        // tods is bit 0, fromds bit 1 of the second frame control byte
        ds_d = {data_byte_i[0], data_byte_i[1]};
      end else if (rel >= ADDR1_START && rel < ADDR1_START + MAC_BYTES) begin
        addr1_d = {addr1_q[39:0], data_byte_i};
      end else if (rel >= ADDR2_START && rel < ADDR2_START + MAC_BYTES) begin
        addr2_d = {addr2_q[39:0], data_byte_i};
      end else if (rel >= ADDR3_START && rel < ADDR3_START + MAC_BYTES) begin
        addr3_d = {addr3_q[39:0], data_byte_i};
      end else if (ds_q == DS_BOTH && rel >= ADDR4_START && rel < ADDR4_START + MAC_BYTES) begin
        addr4_d = {addr4_q[39:0], data_byte_i};
      end
    end

    // type field and ip header move later by one address in four-address frames
    ip_start = TYPE_START + TYPE_BYTES + ((ds_d == DS_BOTH) ? MAC_BYTES : 16'd0);
    ip_off   = rel - ip_start;
    hidx     = ip_off[4:0];
    in_ip    = in_body && rel >= ip_start && rel < ip_start + IP_HDR_BYTES;
    complete = in_body && rel >= ip_start + IP_HDR_BYTES - 16'd1;

    if (in_body && rel >= ip_start - TYPE_BYTES && rel < ip_start) begin
      etype_d = {etype_q[7:0], data_byte_i};
    end else if (in_ip) begin
      if (hidx == IPH_IHL) begin
        ihl_d = data_byte_i[3:0];
      end else if (hidx == IPH_LEN_HI || hidx == IPH_LEN_LO) begin
        iplen_d = {iplen_q[7:0], data_byte_i};
      end else if (hidx == IPH_CSUM_HI || hidx == IPH_CSUM_LO) begin
        csum_d = {csum_q[7:0], data_byte_i};
      end else if (hidx >= IPH_SRC_LO && hidx <= IPH_SRC_HI) begin
        ipsrc_d = {ipsrc_q[23:0], data_byte_i};
      end else if (hidx >= IPH_DST_LO && hidx <= IPH_DST_HI) begin
        ipdst_d = {ipdst_q[23:0], data_byte_i};
      end
    end

    case (ds_d)
      DS_NONE: begin
        da = addr1_d;
        sa = addr2_d;
      end
      DS_FROM: begin
        da = addr1_d;
        sa = addr3_d;
      end
      DS_TO: begin
        da = addr3_d;
        sa = addr2_d;
      end
      default: begin
        da = addr3_d;
        sa = addr4_d;
      end
    endcase

    res = '0;
    if (complete) begin
      res.for_this_host   = (ipdst_d == own_ip_q);
      res.dest_ip         = ipdst_d;
      res.source_ip       = ipsrc_d;
      res.header_checksum = csum_d;
      res.packet_length   = iplen_d;
      res.header_bytes    = {ihl_d, 2'b00};
      res.is_ip_type      = (etype_d == IP_ETHER_TYPE);
      res.four_address    = (ds_d == DS_BOTH);
      res.dest_mac        = da;
      res.source_mac      = sa;
    end else begin
      res.status = 1'b1;
    end

    if (last_byte_i) begin
      // frame done: clear everything but own_ip
      pos_d   = '0;
      ds_d    = '0;
      addr1_d = '0;
      addr2_d = '0;
      addr3_d = '0;
      addr4_d = '0;
      etype_d = '0;
      ihl_d   = '0;
      iplen_d = '0;
      csum_d  = '0;
      ipsrc_d = '0;
      ipdst_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i) begin
      own_ip_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ds_q    <= '0;
      addr1_q <= '0;
      addr2_q <= '0;
      addr3_q <= '0;
      addr4_q <= '0;
      etype_q <= '0;
      ihl_q   <= '0;
      iplen_q <= '0;
      csum_q  <= '0;
      ipsrc_q <= '0;
      ipdst_q <= '0;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      ds_q    <= ds_d;
      addr1_q <= addr1_d;
      addr2_q <= addr2_d;
      addr3_q <= addr3_d;
      addr4_q <= addr4_d;
      etype_q <= etype_d;
      ihl_q   <= ihl_d;
      iplen_q <= iplen_d;
      csum_q  <= csum_d;
      ipsrc_q <= ipsrc_d;
      ipdst_q <= ipdst_d;
    end
  end

  // two-entry output buffer; push never happens while the skid entry is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push;
      end
    end else if (push) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= res;
      end
    end else if (push) begin
      if (main_v_q) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

  assign out_valid_o       = main_v_q;
  assign for_this_host_o   = main_q.for_this_host;
  assign dest_ip_o         = main_q.dest_ip;
  assign source_ip_o       = main_q.source_ip;
  assign header_checksum_o = main_q.header_checksum;
  assign packet_length_o   = main_q.packet_length;
  assign header_bytes_o    = main_q.header_bytes;
  assign is_ip_type_o      = main_q.is_ip_type;
  assign four_address_o    = main_q.four_address;
  assign dest_mac_o        = main_q.dest_mac;
  assign source_mac_o      = main_q.source_mac;
  assign status_o          = main_q.status;

endmodule
